[src/stk_pkg.sv]
// ----------------------------------------------------------------------------
// stk_pkg
// Shared widths, beat types and cell control for the streaming top-k selector.
// ----------------------------------------------------------------------------
`default_nettype none

package stk_pkg;

  // Sizes of the kept list and of one set
  localparam int MAX_K  = 64;
  localparam int MAX_N  = 4096;

  // Field and counter widths
  localparam int SCORE_W = 32;
  localparam int POS_W   = 12;
  localparam int CNT_W   = 13;   // arrival counter, holds MAX_N itself
  localparam int SEL_W   = 7;
  localparam int FILL_W  = 7;    // fill count, holds MAX_K itself

  // Controller states
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  // Input beat: one score
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      end_of_set;
  } in_beat_t;

  // Output beat: one selected position
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             final_pick;
  } out_beat_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic insert;       // place the new score in its sorted slot
    logic drain_shift;  // move every entry one cell toward the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

[src/stk_cell.sv]
// ----------------------------------------------------------------------------
// stk_cell
// One slot of the sorted insertion chain: score, position and the compare.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_cell (
  input  wire                                  clk,
  input  wire stk_pkg::cell_ctrl_t             ctrl,
  input  wire                                  valid,
  input  wire logic signed [stk_pkg::SCORE_W-1:0] new_score,
  input  wire logic        [stk_pkg::POS_W-1:0]   new_pos,
  input  wire                                  prev_take,
  input  wire logic signed [stk_pkg::SCORE_W-1:0] prev_score,
  input  wire logic        [stk_pkg::POS_W-1:0]   prev_pos,
  input  wire logic signed [stk_pkg::SCORE_W-1:0] next_score,
  input  wire logic        [stk_pkg::POS_W-1:0]   next_pos,
  output logic                                 take,
  output logic signed [stk_pkg::SCORE_W-1:0]   score,
  output logic        [stk_pkg::POS_W-1:0]     pos
);

  // Claim the new score when this slot is empty or ranks strictly below it
  assign take = !valid || (score < new_score);

  // Drain toward the head, shift behind the insertion point, or load the new entry
  always_ff @(posedge clk) begin
    if (ctrl.drain_shift) begin
      score <= next_score;
      pos   <= next_pos;
    end else if (ctrl.insert) begin
      if (prev_take) begin
        score <= prev_score;
        pos   <= prev_pos;
      end else if (take) begin
        score <= new_score;
        pos   <= new_pos;
      end
    end
  end

endmodule

`default_nettype wire

[src/stable_top_k_index_select_unit.sv]
// ----------------------------------------------------------------------------
// stable_top_k_index_select_unit
// Streaming top-k selector: keeps the best scores of a set and returns
// their arrival positions, best first, when the set closes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one signed Q16.16 score
//   per beat; beats are numbered 0, 1, 2 ... within a set. A beat with
//   end_of_set closes the set. Scores past MAX_N in one set are not kept.
//   While a set is open, one score is taken every cycle: each beat goes to a
//   chain of MAX_K cells that compare it in parallel and shift as it is taken.
//   Equal scores keep arrival order.
//   On the closing beat, min(select_count, kept) positions leave on the
//   output channel (out_valid/out_ready/out_data), the first in the cycle after
//   the closing beat, then one per cycle while out_ready is high; the last
//   carries final_pick. The cells drain toward the head, one per output beat.
//   During draining in_ready is low, so no new score is taken until the last
//   result has left; with nothing to return the block is ready again in the
//   next cycle. A stall on out_ready holds the current beat.
//   cfg_we/cfg_wdata write select_count (reset 64, values above 64 act as 64).
//   Reset empties the list, clears the arrival count and drops any drain.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_top_k_index_select_unit (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire stk_pkg::in_beat_t         in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output stk_pkg::out_beat_t             out_data,
  input  wire                            cfg_we,
  input  wire logic [stk_pkg::SEL_W-1:0] cfg_wdata
);

  localparam int K = stk_pkg::MAX_K;

  // Control registers
  logic                        state;
  logic [stk_pkg::SEL_W-1:0]   select_count;
  logic [stk_pkg::FILL_W-1:0]  fill;
  logic [stk_pkg::CNT_W-1:0]   arrival;
  logic [stk_pkg::FILL_W-1:0]  remaining;

  // Chain wiring
  stk_pkg::cell_ctrl_t                   ctrl;
  logic [K-1:0]                          cell_take;
  logic [K-1:0]                          cell_valid;
  logic signed [stk_pkg::SCORE_W-1:0]    cell_score [K];
  logic        [stk_pkg::POS_W-1:0]      cell_pos   [K];

  logic                        in_fire;
  logic                        out_fire;
  logic                        keep_item;
  logic                        fill_inc;
  logic [stk_pkg::FILL_W-1:0]  fill_after;
  logic [stk_pkg::FILL_W-1:0]  sel_clamp;
  logic [stk_pkg::FILL_W-1:0]  pick_count;

  // Handshakes
  assign in_ready  = (state == stk_pkg::ST_IDLE);
  assign out_valid = (state == stk_pkg::ST_DRAIN);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // Keep scores only while the set is within MAX_N
  assign keep_item  = in_fire && (arrival < stk_pkg::CNT_W'(stk_pkg::MAX_N));
  assign fill_inc   = keep_item && (fill < stk_pkg::FILL_W'(K));
  assign fill_after = fill + stk_pkg::FILL_W'(fill_inc);

  // Result count for the closing beat
  assign sel_clamp  = (select_count > stk_pkg::SEL_W'(K)) ? stk_pkg::FILL_W'(K)
                                                          : select_count;
  assign pick_count = (sel_clamp < fill_after) ? sel_clamp : fill_after;

  assign ctrl.insert      = keep_item;
  assign ctrl.drain_shift = out_fire;

  // Build the chain of cells
  for (genvar i = 0; i < K; i++) begin : g_cell
    logic                               p_take;
    logic signed [stk_pkg::SCORE_W-1:0] p_score;
    logic        [stk_pkg::POS_W-1:0]   p_pos;
    logic signed [stk_pkg::SCORE_W-1:0] n_score;
    logic        [stk_pkg::POS_W-1:0]   n_pos;

    assign cell_valid[i] = (stk_pkg::FILL_W'(i) < fill);

    if (i == 0) begin : g_head
      assign p_take  = 1'b0;
      assign p_score = cell_score[i];
      assign p_pos   = cell_pos[i];
    end else begin : g_body
      assign p_take  = cell_take[i-1];
      assign p_score = cell_score[i-1];
      assign p_pos   = cell_pos[i-1];
    end

    if (i == K-1) begin : g_tail
      assign n_score = cell_score[i];
      assign n_pos   = cell_pos[i];
    end else begin : g_inner
      assign n_score = cell_score[i+1];
      assign n_pos   = cell_pos[i+1];
    end

    stk_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (cell_valid[i]),
      .new_score  (in_data.score),
      .new_pos    (arrival[stk_pkg::POS_W-1:0]),
      .prev_take  (p_take),
      .prev_score (p_score),
      .prev_pos   (p_pos),
      .next_score (n_score),
      .next_pos   (n_pos),
      .take       (cell_take[i]),
      .score      (cell_score[i]),
      .pos        (cell_pos[i])
    );
  end

  // Output beat comes straight from the head cell
  assign out_data.position   = cell_pos[0];
  assign out_data.final_pick = (remaining == stk_pkg::FILL_W'(1));

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      select_count <= stk_pkg::SEL_W'(K);
    end else if (cfg_we) begin
      select_count <= cfg_wdata;
    end
  end

  // Set bookkeeping and drain sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stk_pkg::ST_IDLE;
      fill      <= '0;
      arrival   <= '0;
      remaining <= '0;
    end else if (state == stk_pkg::ST_IDLE) begin
      if (in_fire) begin
        if (in_data.end_of_set) begin
          remaining <= pick_count;
          if (pick_count == '0) begin
            fill    <= '0;
            arrival <= '0;
          end else begin
            fill  <= fill_after;
            state <= stk_pkg::ST_DRAIN;
          end
        end else begin
          fill <= fill_after;
          if (keep_item) begin
            arrival <= arrival + stk_pkg::CNT_W'(1);
          end
        end
      end
    end else if (out_fire) begin
      remaining <= remaining - stk_pkg::FILL_W'(1);
      if (remaining == stk_pkg::FILL_W'(1)) begin
        state   <= stk_pkg::ST_IDLE;
        fill    <= '0;
        arrival <= '0;
      end
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= stk_pkg::FILL_W'(K))
    else $error("fill count exceeds list depth");

  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (remaining != '0) && (remaining <= fill))
    else $error("drain count out of range");

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while draining");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_data.final_pick) |=> (fill == '0) && (arrival == '0) && in_ready)
    else $error("set not cleared after final pick");

endmodule

`default_nettype wire
